// File: hw/rtl/ebpf_pkg.sv
package ebpf_pkg;

    localparam int PoolDepth = 64;
    localparam int PtrW      = $clog2(PoolDepth);
    localparam int CntW      = $clog2(PoolDepth + 1);
    localparam int WordW     = 32;
    localparam int ByteW     = 8;
    localparam int OutCntW   = 7;
    localparam int PctProdW  = CntW + 7;
    localparam int OutDataW  = ((WordW + 2 * OutCntW + 7) / 8) * 8;

    typedef enum logic {
        t_op_harvest = 1'b0,
        t_op_pop     = 1'b1
    } t_op;

    typedef logic [PtrW-1:0] t_ptr;
    typedef logic [CntW-1:0] t_cnt;

    localparam t_ptr LastPtr   = t_ptr'(PoolDepth - 1);
    localparam t_cnt FullCount = t_cnt'(PoolDepth);

    function automatic t_ptr next_ptr(input t_ptr p);
        return (p == LastPtr) ? '0 : t_ptr'(p + 1'b1);
    endfunction

    function automatic logic [OutCntW-1:0] percent_of(input t_cnt c);
        logic [PctProdW-1:0] prod;
        prod = PctProdW'(c) * PctProdW'(100);
        return OutCntW'(prod / PoolDepth);
    endfunction

endpackage

// File: hw/rtl/entropy_byte_pool_fifo.sv
// Entropy byte pool. Harvest and pop requests arrive on the slave stream; the
// tuser bit selects the request (0 harvests tdata[7:0], 1 pops one word).
// A harvest packs the byte little-endian into a 32-bit word while the
// hysteresis gate is open; every fourth byte pushes the word into a 64-entry
// pool memory. The gate closes when the pool is full and reopens on the first
// harvest that finds it empty. A harvest produces no transaction on the
// master stream.
// A pop produces one master transaction in the cycle after acceptance: the
// oldest word (zero if the pool was empty), the empty flag in tuser, and the
// fill count and integer percent full after the pop.
// One request per cycle unless stalled; the pool memory has one write and one
// registered read port, and the read data register is the result register.
// If the receiver stalls with a result pending, tready drops and the result
// holds until it is taken. Reset empties the pool, clears the packer, opens
// the gate and clears the pending result; no clearing pass is needed.
module entropy_byte_pool_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // sample_byte
    input  logic [ebpf_pkg::ByteW-1:0]       i_s_axis_tdata,
    // op
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // word, fill_count, fill_percent, zero padding
    output logic [ebpf_pkg::OutDataW-1:0]    o_m_axis_tdata,
    // was_empty
    output logic                             o_m_axis_tuser
);

    logic [ebpf_pkg::WordW-1:0]   r_mem [ebpf_pkg::PoolDepth];
    logic [ebpf_pkg::WordW-1:0]   r_word;
    ebpf_pkg::t_ptr               r_rptr, n_rptr;
    ebpf_pkg::t_ptr               r_wptr, n_wptr;
    ebpf_pkg::t_cnt               r_count, n_count;
    logic [23:0]                  r_partial, n_partial;
    logic [1:0]                   r_nbytes, n_nbytes;
    logic                         r_gate, n_gate;
    logic                         r_out_valid, n_out_valid;
    logic                         r_empty, n_empty;
    logic [ebpf_pkg::OutCntW-1:0] r_fill, n_fill;
    logic [ebpf_pkg::OutCntW-1:0] r_pct, n_pct;
    logic                         in_acc, is_pop, is_harv, push, do_pop;
    logic [ebpf_pkg::WordW-1:0]   push_word;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign is_pop  = in_acc && (ebpf_pkg::t_op'(i_s_axis_tuser) == ebpf_pkg::t_op_pop);
    assign is_harv = in_acc && (ebpf_pkg::t_op'(i_s_axis_tuser) == ebpf_pkg::t_op_harvest);
    assign do_pop  = is_pop && (r_count != '0);
    assign push_word = {i_s_axis_tdata, r_partial};

    always_comb begin
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_count     = r_count;
        n_partial   = r_partial;
        n_nbytes    = r_nbytes;
        n_gate      = r_gate;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_empty     = r_empty;
        n_fill      = r_fill;
        n_pct       = r_pct;
        push        = 1'b0;
        if (is_harv) begin
            if (r_count >= ebpf_pkg::FullCount) begin
                n_gate = 1'b0;
            end else if (r_count == '0) begin
                n_gate = 1'b1;
            end
            if (n_gate) begin
                if (r_nbytes == 2'd3) begin
                    n_partial = '0;
                    n_nbytes  = '0;
                    if (r_count < ebpf_pkg::FullCount) begin
                        push    = 1'b1;
                        n_wptr  = ebpf_pkg::next_ptr(r_wptr);
                        n_count = ebpf_pkg::t_cnt'(r_count + 1'b1);
                    end
                end else begin
                    n_partial = r_partial | (24'(i_s_axis_tdata) << {r_nbytes, 3'b000});
                    n_nbytes  = 2'(r_nbytes + 1'b1);
                end
            end
        end
        if (is_pop) begin
            n_out_valid = 1'b1;
            n_empty     = (r_count == '0);
            if (do_pop) begin
                n_rptr  = ebpf_pkg::next_ptr(r_rptr);
                n_count = ebpf_pkg::t_cnt'(r_count - 1'b1);
            end
            n_fill = ebpf_pkg::OutCntW'(n_count);
            n_pct  = ebpf_pkg::percent_of(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_count     <= '0;
            r_partial   <= '0;
            r_nbytes    <= '0;
            r_gate      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_count     <= n_count;
            r_partial   <= n_partial;
            r_nbytes    <= n_nbytes;
            r_gate      <= n_gate;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_empty <= n_empty;
        r_fill  <= n_fill;
        r_pct   <= n_pct;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= push_word;
        end
        if (is_pop) begin
            r_word <= do_pop ? r_mem[r_rptr] : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_empty;
    assign o_m_axis_tdata  = ebpf_pkg::OutDataW'({r_pct, r_fill, r_word});

    // The occupancy never exceeds the pool depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ebpf_pkg::FullCount)
        else $error("pool count above depth");

    // The pointers and the count stay consistent.
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ebpf_pkg::t_ptr'(r_wptr - r_rptr) == ebpf_pkg::t_ptr'(r_count))
        else $error("pointers disagree with count");

    // A pop on an empty pool reports empty with a zero word and zero fill.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_pop && r_count == '0) |=>
            (o_m_axis_tvalid && o_m_axis_tuser && r_word == '0 && r_fill == '0))
        else $error("empty pop result wrong");

    // A pop on a non-empty pool reports one word fewer.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> (!o_m_axis_tuser && r_count == ebpf_pkg::t_cnt'($past(r_count) - 1'b1)))
        else $error("pop did not remove one word");

    // A harvest never creates a new result transaction.
    a_harv_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_harv && !r_out_valid) |=> !o_m_axis_tvalid)
        else $error("harvest produced a result");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int IdlePercent   = 32;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 8;
    localparam int PhaseItems    = 6;
    localparam int PhaseCount    = 8;

    typedef struct packed {
        logic [ebpf_pkg::WordW-1:0]   word;
        logic                         was_empty;
        logic [ebpf_pkg::OutCntW-1:0] fill_count;
        logic [ebpf_pkg::OutCntW-1:0] fill_percent;
    } t_pop_result;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic [ebpf_pkg::ByteW-1:0]    s_tdata     = '0;
    logic                          s_tuser     = 1'b0;
    logic                          m_ready     = 1'b0;
    logic                          o_s_axis_tready;
    logic                          o_m_axis_tvalid;
    logic [ebpf_pkg::OutDataW-1:0] o_m_axis_tdata;
    logic                          o_m_axis_tuser;

    logic [ebpf_pkg::WordW-1:0]    pool_words [ebpf_pkg::PoolDepth];
    int                            pool_count    = 0;
    int                            rd_idx        = 0;
    int                            wr_idx        = 0;
    logic [23:0]                   partial_bytes = '0;
    int                            packed_bytes  = 0;
    logic                          gate_open     = 1'b1;
    t_pop_result                   expected_pops [$];

    bit                            idle_on       = 1'b1;
    int                            error_count   = 0;
    int                            quiet_cycles  = 0;
    int                            harvest_count = 0;
    int                            ignored_count = 0;
    int                            pop_count     = 0;
    int                            empty_pops    = 0;
    int                            gate_closures = 0;
    int                            words_pushed  = 0;

    entropy_byte_pool_fifo dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void update_pool(input ebpf_pkg::t_op op,
                                        input logic [ebpf_pkg::ByteW-1:0] sample);
        t_pop_result res;
        if (op == ebpf_pkg::t_op_harvest) begin
            harvest_count++;
            if (pool_count >= ebpf_pkg::PoolDepth) begin
                if (gate_open) gate_closures++;
                gate_open = 1'b0;
            end else if (pool_count == 0) begin
                gate_open = 1'b1;
            end
            if (!gate_open) begin
                ignored_count++;
            end else if (packed_bytes == 3) begin
                if (pool_count < ebpf_pkg::PoolDepth) begin
                    pool_words[wr_idx] = {sample, partial_bytes};
                    wr_idx = (wr_idx + 1) % ebpf_pkg::PoolDepth;
                    pool_count++;
                    words_pushed++;
                end
                partial_bytes = '0;
                packed_bytes  = 0;
            end else begin
                partial_bytes[packed_bytes*8 +: 8] = sample;
                packed_bytes++;
            end
        end else begin
            pop_count++;
            res.word      = '0;
            res.was_empty = 1'b1;
            if (pool_count != 0) begin
                res.word      = pool_words[rd_idx];
                rd_idx        = (rd_idx + 1) % ebpf_pkg::PoolDepth;
                pool_count--;
                res.was_empty = 1'b0;
            end else begin
                empty_pops++;
            end
            res.fill_count   = ebpf_pkg::OutCntW'(pool_count);
            res.fill_percent = ebpf_pkg::OutCntW'((pool_count * 100) / ebpf_pkg::PoolDepth);
            expected_pops.push_back(res);
        end
    endfunction

    function automatic void check_pop_result();
        t_pop_result exp;
        t_pop_result act;
        act.word         = o_m_axis_tdata[ebpf_pkg::WordW-1:0];
        act.fill_count   = o_m_axis_tdata[ebpf_pkg::WordW +: ebpf_pkg::OutCntW];
        act.fill_percent =
            o_m_axis_tdata[ebpf_pkg::WordW+ebpf_pkg::OutCntW +: ebpf_pkg::OutCntW];
        act.was_empty    = o_m_axis_tuser;
        if (expected_pops.size() == 0) begin
            $error("result transaction with no pop pending: word %h", act.word);
            error_count++;
        end else begin
            exp = expected_pops.pop_front();
            if (act.word !== exp.word) begin
                $error("word: expected %h, actual %h", exp.word, act.word);
                error_count++;
            end
            if (act.was_empty !== exp.was_empty) begin
                $error("was_empty: expected %0d, actual %0d", exp.was_empty, act.was_empty);
                error_count++;
            end
            if (act.fill_count !== exp.fill_count) begin
                $error("fill_count: expected %0d, actual %0d", exp.fill_count, act.fill_count);
                error_count++;
            end
            if (act.fill_percent !== exp.fill_percent) begin
                $error("fill_percent: expected %0d, actual %0d",
                       exp.fill_percent, act.fill_percent);
                error_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready) begin
                update_pool(ebpf_pkg::t_op'(s_tuser), s_tdata);
            end
            if (o_m_axis_tvalid && m_ready) begin
                check_pop_result();
            end
        end
    end

    always @(negedge i_clk) begin
        m_ready <= idle_on ? ($urandom_range(0, 99) >= IdlePercent) : 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WatchdogLimit) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic send_request(input ebpf_pkg::t_op op,
                                input logic [ebpf_pkg::ByteW-1:0] sample);
        while (idle_on && ($urandom_range(0, 99) < IdlePercent)) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_tdata <= sample;
        s_tuser <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic harvest(input logic [ebpf_pkg::ByteW-1:0] sample);
        send_request(ebpf_pkg::t_op_harvest, sample);
    endtask

    task automatic pop();
        send_request(ebpf_pkg::t_op_pop, ebpf_pkg::ByteW'($urandom_range(0, 255)));
    endtask

    task automatic test_empty_pool();
        pop();
        pop();
    endtask

    task automatic test_byte_packing();
        harvest(8'h00);
        harvest(8'hFF);
        harvest(8'h55);
        harvest(8'hAA);
        harvest(8'h01);
        harvest(8'h80);
        harvest(8'h7F);
        harvest(8'hFE);
        pop();
        pop();
        pop();
        harvest(8'hA5);
        harvest(8'h5A);
        harvest(8'hC3);
        pop();
        harvest(8'h3C);
        pop();
    endtask

    // Fill the pool, refill it after one pop while the gate is still open,
    // then close the gate, drain it fully and reopen it with a fresh word.
    task automatic test_gate_hysteresis();
        idle_on = 1'b0;
        repeat (ebpf_pkg::PoolDepth * 4) harvest(ebpf_pkg::ByteW'($urandom_range(0, 255)));
        idle_on = 1'b1;
        pop();
        repeat (4) harvest(ebpf_pkg::ByteW'($urandom_range(0, 255)));
        repeat (5) harvest(ebpf_pkg::ByteW'($urandom_range(0, 255)));
        repeat (2) pop();
        repeat (8) harvest(ebpf_pkg::ByteW'($urandom_range(0, 255)));
        repeat (ebpf_pkg::PoolDepth - 2) pop();
        pop();
        repeat (4) harvest(ebpf_pkg::ByteW'($urandom_range(0, 255)));
        pop();
    endtask

    task automatic test_random_traffic();
        int harvest_weight [PhaseCount] = '{20, 50, 80, 95, 35, 65, 90, 50};
        for (int phase = 0; phase < PhaseCount; phase++) begin
            idle_on = (phase != 3);
            repeat (PhaseItems) begin
                if ($urandom_range(0, 99) < harvest_weight[phase]) begin
                    harvest(ebpf_pkg::ByteW'($urandom_range(0, 255)));
                end else begin
                    pop();
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pool();
        test_byte_packing();
        test_gate_hysteresis();
        test_random_traffic();

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (expected_pops.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Run covered %0d harvests (%0d dropped by the closed gate)",
                 harvest_count, ignored_count);
        $display("and %0d pops (%0d empty); the gate closed %0d times, %0d words pooled.",
                 pop_count, empty_pops, gate_closures, words_pushed);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
